### sv/packet_deframer_sum_checksum_top_defines.svh
// Assertion macros used by the deframer top level.
`ifndef PACKET_DEFRAMER_SUM_CHECKSUM_TOP_DEFINES_SVH
`define PACKET_DEFRAMER_SUM_CHECKSUM_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PDSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdsc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PDSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdsc next-cycle check failed");

`endif

### sv/pdsc_pkg.sv
`default_nettype none

package pdsc_pkg;

   localparam int BufferBytes = 256;
   localparam int EmptySize   = 6;
   localparam int BodyOffset  = 4;
   localparam logic [7:0]  CheckXor     = 8'hAA;
   localparam logic [15:0] MaxLength    = 16'(BufferBytes - EmptySize);
   localparam logic [7:0]  StartReset   = 8'd0;
   localparam logic [15:0] TimeoutReset = 16'd500;

   // input command
   localparam logic CmdByte = 1'b0;
   localparam logic CmdTick = 1'b1;

   // result kinds
   localparam logic [1:0] KindBody   = 2'd0;
   localparam logic [1:0] KindAccept = 2'd1;
   localparam logic [1:0] KindError  = 2'd2;

   // error codes
   localparam logic [2:0] ErrBadStart = 3'd0;
   localparam logic [2:0] ErrShort    = 3'd1;
   localparam logic [2:0] ErrLong     = 3'd2;
   localparam logic [2:0] ErrChecksum = 3'd3;
   localparam logic [2:0] ErrTimeout  = 3'd4;

   // register indexes
   localparam logic [1:0] CsrStartMarker  = 2'd0;
   localparam logic [1:0] CsrTimeoutTicks = 2'd1;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [2:0] error_code;
      logic [7:0] body_length;
      logic [7:0] packet_code;
      logic [7:0] body_index;
      logic [7:0] body_byte;
   } rsp_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } skid_status_type;

endpackage

`default_nettype wire

### sv/pdsc_core.sv
`default_nettype none

module pdsc_core #(
   parameter int BUFFER_BYTES = pdsc_pkg::BufferBytes
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pdsc_pkg::cfg_type cfg,
   input  wire logic             beat_valid,
   input  wire logic             beat_command,
   input  wire logic [7:0]       beat_byte,
   output logic                  res_valid,
   output pdsc_pkg::rsp_type     res
);
   import pdsc_pkg::*;

   localparam logic [15:0] LengthLimit = 16'(BUFFER_BYTES - EmptySize);

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_LEN  = 2'd1,
      PH_REST = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  received_sum_ff, received_sum_in;
   logic [7:0]  code_held_ff, code_held_in;
   logic [15:0] tick_count_ff, tick_count_in;

   logic [7:0]  sum_b;
   logic [15:0] pos_plus2;
   logic [15:0] tick_inc;

   assign sum_b     = running_sum_ff + beat_byte;
   assign pos_plus2 = {8'd0, byte_count_ff} + 16'd2;
   assign tick_inc  = (tick_count_ff == 16'hFFFF) ? tick_count_ff : tick_count_ff + 16'd1;

   always_comb begin
      phase_in           = phase_ff;
      byte_count_in      = byte_count_ff;
      declared_length_in = declared_length_ff;
      running_sum_in     = running_sum_ff;
      received_sum_in    = received_sum_ff;
      code_held_in       = code_held_ff;
      tick_count_in      = tick_count_ff;
      res_valid          = 1'b0;
      res                = '0;

      if (beat_command == CmdTick) begin
         if (phase_ff == PH_LEN || phase_ff == PH_REST) begin
            tick_count_in = tick_inc;
            if (tick_inc >= cfg.timeout_ticks) begin
               phase_in        = PH_WAIT;
               byte_count_in   = 8'd0;
               res_valid       = 1'b1;
               res.result_kind = KindError;
               res.error_code  = ErrTimeout;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_LEN: begin
               running_sum_in = sum_b;
               if (byte_count_ff == 8'd1) begin
                  declared_length_in = {8'd0, beat_byte};
                  byte_count_in      = 8'd2;
               end else begin
                  declared_length_in = declared_length_ff | {beat_byte, 8'd0};
                  byte_count_in      = 8'd3;
                  phase_in           = PH_REST;
               end
            end
            PH_REST: begin
               if (byte_count_ff == 8'd3) begin
                  // code byte: length is complete, check its range
                  code_held_in   = beat_byte;
                  running_sum_in = sum_b;
                  byte_count_in  = 8'd4;
                  if (declared_length_ff < 16'(EmptySize)) begin
                     phase_in        = PH_WAIT;
                     byte_count_in   = 8'd0;
                     res_valid       = 1'b1;
                     res.result_kind = KindError;
                     res.error_code  = ErrShort;
                  end else if (declared_length_ff > LengthLimit) begin
                     phase_in        = PH_WAIT;
                     byte_count_in   = 8'd0;
                     res_valid       = 1'b1;
                     res.result_kind = KindError;
                     res.error_code  = ErrLong;
                  end
               end else if (pos_plus2 < declared_length_ff) begin
                  running_sum_in  = sum_b;
                  byte_count_in   = byte_count_ff + 8'd1;
                  res_valid       = 1'b1;
                  res.result_kind = KindBody;
                  res.body_byte   = beat_byte;
                  res.body_index  = byte_count_ff - 8'(BodyOffset);
                  res.packet_code = code_held_ff;
               end else if (pos_plus2 == declared_length_ff) begin
                  received_sum_in = beat_byte;
                  byte_count_in   = byte_count_ff + 8'd1;
               end else begin
                  // last byte: compare both check bytes
                  phase_in      = PH_WAIT;
                  byte_count_in = 8'd0;
                  res_valid     = 1'b1;
                  if (received_sum_ff == running_sum_ff &&
                      beat_byte == (running_sum_ff ^ CheckXor)) begin
                     res.result_kind = KindAccept;
                     res.packet_code = code_held_ff;
                     res.body_length = declared_length_ff[7:0] - 8'(EmptySize);
                  end else begin
                     res.result_kind = KindError;
                     res.error_code  = ErrChecksum;
                  end
               end
            end
            default: begin
               if (beat_byte != cfg.start_marker) begin
                  phase_in        = PH_WAIT;
                  byte_count_in   = 8'd0;
                  res_valid       = 1'b1;
                  res.result_kind = KindError;
                  res.error_code  = ErrBadStart;
               end else begin
                  phase_in           = PH_LEN;
                  byte_count_in      = 8'd1;
                  running_sum_in     = beat_byte;
                  declared_length_in = 16'd0;
                  received_sum_in    = 8'd0;
                  tick_count_in      = 16'd0;
               end
            end
         endcase
      end

      if (!beat_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_WAIT;
         byte_count_ff      <= 8'd0;
         declared_length_ff <= 16'd0;
         running_sum_ff     <= 8'd0;
         received_sum_ff    <= 8'd0;
         code_held_ff       <= 8'd0;
         tick_count_ff      <= 16'd0;
      end else if (beat_valid) begin
         phase_ff           <= phase_in;
         byte_count_ff      <= byte_count_in;
         declared_length_ff <= declared_length_in;
         running_sum_ff     <= running_sum_in;
         received_sum_ff    <= received_sum_in;
         code_held_ff       <= code_held_in;
         tick_count_ff      <= tick_count_in;
      end
   end

endmodule

`default_nettype wire

### sv/pdsc_skid.sv
`default_nettype none

module pdsc_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pdsc_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pdsc_pkg::rsp_type      out_data,
   output pdsc_pkg::skid_status_type status
);
   import pdsc_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    pop;

   assign in_ready   = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;
   assign pop        = main_valid_ff && out_ready;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // refill the output from the skid stage
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || pop) begin
            main_ff       <= in_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

### sv/packet_deframer_sum_checksum_top.sv
// Channel   Direction  Payload
// req_      in         tuser: command; tdata: rx_byte
// rsp_      out        tuser: result_kind; tdata: body_byte, body_index,
//                      packet_code, body_length, error_code
// csr_      in         index: register number; data: register value
//
// One beat is taken per cycle while req_tready is high; its result is registered
// in the output register, or in the one-entry skid stage when the output is
// stalled. req_tready drops only when the skid stage is full. Synchronous
// reset clears state, start_marker to 0 and timeout_ticks to 500.
// Configuration writes are taken in any cycle.
`default_nettype none
`include "packet_deframer_sum_checksum_top_defines.svh"

module packet_deframer_sum_checksum_top #(
   parameter int BUFFER_BYTES = pdsc_pkg::BufferBytes
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // [0] command
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // [1:0] result_kind
   output logic [39:0]      rsp_tdata,   // [7:0] body_byte, [15:8] body_index,
                                         // [23:16] packet_code, [31:24] body_length,
                                         // [34:32] error_code, [39:35] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import pdsc_pkg::*;

   cfg_type         cfg_ff;
   logic            beat;
   logic            res_valid;
   rsp_type         res;
   rsp_type         out_res;
   skid_status_type skid_status;

   assign csr_ready = 1'b1;
   assign beat      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker  <= StartReset;
         cfg_ff.timeout_ticks <= TimeoutReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrStartMarker:  cfg_ff.start_marker  <= csr_data[7:0];
            CsrTimeoutTicks: cfg_ff.timeout_ticks <= csr_data;
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   pdsc_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .beat_valid   (beat),
      .beat_command (req_tuser),
      .beat_byte    (req_tdata),
      .res_valid    (res_valid),
      .res          (res)
   );

   pdsc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res),
      .status    (skid_status)
   );

   assign rsp_tuser = out_res.result_kind;
   assign rsp_tdata = {5'd0, out_res.error_code, out_res.body_length,
                       out_res.packet_code, out_res.body_index, out_res.body_byte};

   `PDSC_ASSERT_IMPL(a_skid_behind_main, clock, reset, skid_status.skid_valid, skid_status.main_valid)
   `PDSC_ASSERT_IMPL(a_stall_has_result, clock, reset, !req_tready, rsp_tvalid)
   `PDSC_ASSERT_NEXT(a_stalled_result_fills_skid, clock, reset,
                     res_valid && rsp_tvalid && !rsp_tready, !req_tready)
   `PDSC_ASSERT_IMPL(a_kind_known, clock, reset, rsp_tvalid,
                     rsp_tuser == KindBody || rsp_tuser == KindAccept || rsp_tuser == KindError)

endmodule

`default_nettype wire

### tb/packet_deframer_sum_checksum_top_tb.sv
`timescale 1ns / 100ps

module packet_deframer_sum_checksum_top_tb;
   import pdsc_pkg::*;

   localparam int CycleLimit = 800_000;
   // indexes past the two real registers, written to confirm they are ignored
   localparam logic [1:0] CsrSpareLo = 2'd2;
   localparam logic [1:0] CsrSpareHi = 2'd3;

   typedef enum logic [1:0] {PhaseIdle, PhaseLength, PhaseRest} frame_phase_type;
   typedef enum int {FlawNone, FlawSum, FlawXor, FlawTrunc} flaw_type;

   class frame_tracker;
      logic [7:0]      start_marker;
      logic [15:0]     timeout_ticks;
      frame_phase_type phase;
      logic [7:0]      byte_count;
      logic [15:0]     declared_len;
      logic [7:0]      running_sum;
      logic [7:0]      received_sum;
      logic [7:0]      code_held;
      logic [15:0]     tick_count;
      rsp_type         pending[$];
      int              mismatches;
      int              n_checked;
      int              n_body;
      int              n_accept;
      int              n_err[5];

      function new();
         start_marker  = StartReset;
         timeout_ticks = TimeoutReset;
         phase         = PhaseIdle;
         byte_count    = '0;
         declared_len  = '0;
         running_sum   = '0;
         received_sum  = '0;
         code_held     = '0;
         tick_count    = '0;
         mismatches    = 0;
         n_checked     = 0;
         n_body        = 0;
         n_accept      = 0;
         foreach (n_err[i]) n_err[i] = 0;
      endfunction

      function void apply_write(logic [1:0] idx, logic [15:0] val);
         if (idx == CsrStartMarker) start_marker = val[7:0];
         else if (idx == CsrTimeoutTicks) timeout_ticks = val;
      endfunction

      function bit in_frame();
         return phase != PhaseIdle;
      endfunction

      function void queue_result(logic [1:0] kind, logic [7:0] data_byte, logic [7:0] idx,
                                 logic [7:0] code, logic [7:0] blen, logic [2:0] err);
         rsp_type r;
         r.result_kind = kind;
         r.body_byte   = data_byte;
         r.body_index  = idx;
         r.packet_code = code;
         r.body_length = blen;
         r.error_code  = err;
         pending.push_back(r);
      endfunction

      function void drop_frame(logic [2:0] err);
         phase      = PhaseIdle;
         byte_count = '0;
         queue_result(KindError, 8'h00, 8'h00, 8'h00, 8'h00, err);
      endfunction

      // advance the frame state by one accepted input beat
      function void absorb_beat(logic cmd, logic [7:0] rx);
         int pos;
         if (cmd == CmdTick) begin
            if (phase == PhaseIdle) return;
            if (tick_count != 16'hFFFF) tick_count++;
            if (tick_count >= timeout_ticks) drop_frame(ErrTimeout);
            return;
         end
         case (phase)
            PhaseLength: begin
               running_sum += rx;
               if (byte_count == 8'd1) begin
                  declared_len = {8'h00, rx};
                  byte_count   = 8'd2;
               end else begin
                  declared_len[15:8] = rx;
                  byte_count         = 8'd3;
                  phase              = PhaseRest;
               end
            end
            PhaseRest: begin
               pos = byte_count;
               if (pos == 3) begin
                  code_held   = rx;
                  running_sum += rx;
                  byte_count  = 8'd4;
                  if (declared_len < EmptySize) drop_frame(ErrShort);
                  else if (declared_len > MaxLength) drop_frame(ErrLong);
               end else if (pos + 2 < int'(declared_len)) begin
                  running_sum += rx;
                  byte_count++;
                  queue_result(KindBody, rx, 8'(pos - BodyOffset), code_held, 8'h00, 3'd0);
               end else if (pos + 2 == int'(declared_len)) begin
                  received_sum = rx;
                  byte_count++;
               end else if (received_sum == running_sum && rx == (running_sum ^ CheckXor)) begin
                  phase      = PhaseIdle;
                  byte_count = '0;
                  queue_result(KindAccept, 8'h00, 8'h00, code_held,
                               8'(declared_len - EmptySize), 3'd0);
               end else begin
                  drop_frame(ErrChecksum);
               end
            end
            default: begin
               if (rx != start_marker) begin
                  drop_frame(ErrBadStart);
               end else begin
                  phase        = PhaseLength;
                  byte_count   = 8'd1;
                  running_sum  = rx;
                  declared_len = '0;
                  received_sum = '0;
                  tick_count   = '0;
               end
            end
         endcase
      endfunction

      function void match_result(logic [1:0] kind, logic [39:0] data);
         rsp_type want;
         bit      bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result kind %0d data %h", $time, kind, data);
            return;
         end
         want = pending.pop_front();
         n_checked++;
         if (want.result_kind == KindBody) n_body++;
         else if (want.result_kind == KindAccept) n_accept++;
         else n_err[want.error_code]++;
         bad = (kind !== want.result_kind) || (data[7:0] !== want.body_byte) ||
               (data[15:8] !== want.body_index) || (data[23:16] !== want.packet_code) ||
               (data[31:24] !== want.body_length) || (data[34:32] !== want.error_code);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: want kind %0d byte %h idx %0d code %h len %0d err %0d",
                        $time, want.result_kind, want.body_byte, want.body_index,
                        want.packet_code, want.body_length, want.error_code);
               $display("%0t:  got kind %0d byte %h idx %0d code %h len %0d err %0d",
                        $time, kind, data[7:0], data[15:8], data[23:16], data[31:24],
                        data[34:32]);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   frame_tracker tracker = new();
   int           cycle_count = 0;
   int           beats_sent = 0;
   bit           send_gaps = 1'b0;
   bit           rsp_gaps = 1'b0;

   packet_deframer_sum_checksum_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("run stopped after %0d cycles, %0d results still due",
                  cycle_count, tracker.pending.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: hold rsp_tready low at random while enabled
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_gaps && $urandom_range(0, 6) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_result(rsp_tuser, rsp_tdata);
   end

   // entered and left at a falling edge
   task automatic send_beat(input logic cmd, input logic [7:0] rx);
      if (send_gaps && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 13)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = rx;
      do @(posedge clock); while (!req_tready);
      tracker.absorb_beat(cmd, rx);
      beats_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_data(input logic [7:0] rx, input int tick_pct);
      if ($urandom_range(0, 99) < tick_pct) send_beat(CmdTick, 8'($urandom));
      send_beat(CmdByte, rx);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      tracker.apply_write(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // header only: used for lengths the block rejects at the code byte
   task automatic send_header(input logic [7:0] code, input logic [15:0] total,
                              input int tick_pct);
      send_data(tracker.start_marker, tick_pct);
      send_data(total[7:0], tick_pct);
      send_data(total[15:8], tick_pct);
      send_data(code, tick_pct);
   endtask

   task automatic send_packet(input logic [7:0] code, input int body_len, input flaw_type flaw,
                              input int tick_pct);
      logic [7:0]  frame_bytes[$];
      logic [15:0] total;
      logic [7:0]  csum;
      int          cut;
      total = 16'(body_len + EmptySize);
      frame_bytes = '{tracker.start_marker, total[7:0], total[15:8], code};
      repeat (body_len) frame_bytes.push_back(8'($urandom));
      csum = '0;
      foreach (frame_bytes[i]) csum += frame_bytes[i];
      frame_bytes.push_back(flaw == FlawSum ? csum ^ 8'($urandom_range(1, 255)) : csum);
      frame_bytes.push_back(flaw == FlawXor ? csum ^ CheckXor ^ 8'($urandom_range(1, 255))
                                            : csum ^ CheckXor);
      cut = (flaw == FlawTrunc) ? $urandom_range(1, frame_bytes.size() - 1)
                                : frame_bytes.size();
      for (int i = 0; i < cut; i++) send_data(frame_bytes[i], tick_pct);
      // hold the frame open with ticks until it times out
      if (flaw == FlawTrunc)
         while (tracker.in_frame()) send_beat(CmdTick, 8'($urandom));
   endtask

   function automatic int body_len_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88) return $urandom_range(0, 12);
      if (r < 98) return $urandom_range(13, 60);
      return $urandom_range(200, 244);
   endfunction

   task automatic run_phase(input int n_beats, input int tick_pct);
      int stop_at;
      int pick;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_packet(8'($urandom), body_len_pick(), FlawNone, tick_pct);
         else if (pick < 62)
            send_packet(8'($urandom), body_len_pick(), FlawSum, tick_pct);
         else if (pick < 68)
            send_packet(8'($urandom), body_len_pick(), FlawXor, tick_pct);
         else if (pick < 73)
            send_header(8'($urandom), 16'($urandom_range(0, 5)), tick_pct);
         else if (pick < 78)
            send_header(8'($urandom), $urandom_range(0, 2) == 0 ? 16'd251
                        : 16'($urandom_range(252, 65535)), tick_pct);
         else if (pick < 85 && tracker.timeout_ticks <= 16'd64)
            send_packet(8'($urandom), body_len_pick(), FlawTrunc, tick_pct);
         else if (pick < 90)
            send_beat(CmdByte, tracker.start_marker ^ 8'($urandom_range(1, 255)));
         else
            repeat ($urandom_range(1, 4)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CmdByte;
      req_tdata  = 8'h00;
      csr_valid  = 1'b0;
      csr_index  = CsrStartMarker;
      csr_data   = 16'h0000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle tick, bad start, empty body, length bounds, bad sum
      send_beat(CmdTick, 8'h00);
      send_beat(CmdByte, 8'hFF);
      send_packet(8'hFF, 0, FlawNone, 0);
      send_header(8'h5A, 16'd5, 0);
      send_header(8'hA5, 16'd251, 0);
      send_packet(8'h3C, 1, FlawSum, 0);
      wait_idle();
      // a zero timeout expires on the first tick
      write_csr(CsrTimeoutTicks, 16'd0);
      send_beat(CmdByte, tracker.start_marker);
      send_beat(CmdTick, 8'hFF);
      wait_idle();

      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      write_csr(CsrStartMarker, {8'($urandom), 8'hA5});
      write_csr(CsrTimeoutTicks, 16'd1000);
      run_phase(50, 3);
      wait_idle();

      send_gaps = 1'b0;
      write_csr(CsrStartMarker, 16'h00FF);
      write_csr(CsrTimeoutTicks, 16'hFFFF);
      run_phase(40, 5);
      wait_idle();

      send_gaps = 1'b1;
      write_csr(CsrStartMarker, 16'($urandom));
      write_csr(CsrTimeoutTicks, 16'($urandom_range(5, 40)));
      run_phase(35, 15);
      wait_idle();
      run_phase(35, 15);
      wait_idle();

      rsp_gaps = 1'b0;
      write_csr(CsrStartMarker, 16'hFF00);
      write_csr(CsrTimeoutTicks, 16'd1);
      write_csr(CsrSpareLo, 16'($urandom));
      write_csr(CsrSpareHi, 16'hFFFF);
      send_packet(8'($urandom), 244, FlawNone, 0);
      run_phase(35, 2);
      wait_idle();

      send_gaps = 1'b0;
      write_csr(CsrStartMarker, 16'($urandom));
      write_csr(CsrTimeoutTicks, 16'($urandom_range(200, 700)));
      run_phase(50, 3);
      wait_idle();

      $display("%0d beats sent, %0d results checked: %0d body, %0d accepted",
               beats_sent, tracker.n_checked, tracker.n_body, tracker.n_accept);
      $display("errors seen: bad start %0d, short %0d, long %0d, checksum %0d, timeout %0d",
               tracker.n_err[0], tracker.n_err[1], tracker.n_err[2], tracker.n_err[3],
               tracker.n_err[4]);
      if (tracker.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
